[hw/rtl/odcre_pkg.sv]
// ----------------------------------------------------------------------------
// odcre_pkg
// Shared types and constants of the OSD dirty-character refresh encoder.
// ----------------------------------------------------------------------------
package odcre_pkg;

	localparam int COLS_DEF         = 30;
	localparam int ROWS_DEF         = 16;
	localparam int BUFFER_CHARS_DEF = 480;

	// wide enough for any screen index and any BUFFER_CHARS up to 2048
	localparam int XW      = 12;
	localparam int ACT_W   = 9;
	localparam int BUD_W   = 6;
	localparam int QDEPTH  = 64;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int CNT_W   = QAW + 1;
	localparam int CFG_AW  = 4;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_CLEAR   = 2'd1;
	localparam logic [1:0] REQ_REDRAW  = 2'd2;
	localparam logic [1:0] REQ_REFRESH = 2'd3;

	localparam logic [1:0] REG_ACTIVE_CHARS  = 2'd0;
	localparam logic [1:0] REG_INVERT_PIXELS = 2'd1;
	localparam logic [1:0] REG_WRITE_BUDGET  = 2'd2;

	localparam logic [ACT_W-1:0] ACTIVE_CHARS_RST = 9'd480;
	localparam logic [BUD_W-1:0] WRITE_BUDGET_RST = 6'd61;
	localparam logic [BUD_W-1:0] BUDGET_CAP       = 6'd59;

	localparam logic [7:0] ADDR_MODE = 8'h04;
	localparam logic [7:0] ADDR_HIGH = 8'h05;
	localparam logic [7:0] ADDR_LOW  = 8'h06;
	localparam logic [7:0] ADDR_DATA = 8'h07;
	localparam logic [7:0] RUN_END   = 8'hFF;
	localparam logic [7:0] SPACE     = 8'h20;

	typedef enum logic [1:0] {
		WR_MODE,
		WR_HIGH,
		WR_LOW,
		WR_DATA
	} wr_sel_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_PRIME,
		ST_EVAL,
		ST_EMIT,
		ST_TAIL_FF,
		ST_TAIL_MODE,
		ST_FLUSH,
		ST_DRAIN
	} ctrl_state_t;

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_READ,
		Q_LOAD
	} q_state_t;

	typedef struct packed {
		logic          char_we;
		logic          shadow_we;
		logic [XW-1:0] waddr;
		logic [7:0]    char_wdata;
		logic [7:0]    shadow_wdata;
		logic          re;
		logic [XW-1:0] raddr;
	} mem_cmd_t;

	typedef struct packed {
		logic           push;
		logic [QAW-1:0] idx;
		wr_sel_t        sel;
		logic [7:0]     value;
	} q_push_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] total;
		logic             more;
	} q_start_t;

	typedef struct packed {
		wr_sel_t    sel;
		logic [7:0] value;
	} q_entry_t;

	function automatic logic [7:0] sel_addr(input wr_sel_t sel);
		logic [7:0] a;
		case (sel)
			WR_MODE: a = ADDR_MODE;
			WR_HIGH: a = ADDR_HIGH;
			WR_LOW:  a = ADDR_LOW;
			WR_DATA: a = ADDR_DATA;
			default: a = ADDR_DATA;
		endcase
		return a;
	endfunction

endpackage

[hw/rtl/odcre_screen_mem.sv]
// ----------------------------------------------------------------------------
// odcre_screen_mem
// Character store and shadow store: one write and one registered read each.
// ----------------------------------------------------------------------------
module odcre_screen_mem import odcre_pkg::*; #(
	parameter int BUFFER_CHARS = BUFFER_CHARS_DEF
) (
	input  logic       clk,
	input  mem_cmd_t   cmd,
	output logic [7:0] rd_char,
	output logic [7:0] rd_shadow
);

	localparam int AW = $clog2(BUFFER_CHARS);

	logic [7:0] char_mem   [BUFFER_CHARS];
	logic [7:0] shadow_mem [BUFFER_CHARS];
	logic [7:0] rd_char_q;
	logic [7:0] rd_shadow_q;

	always_ff @(posedge clk) begin
		if (cmd.char_we) begin
			char_mem[cmd.waddr[AW-1:0]] <= cmd.char_wdata;
		end
		if (cmd.re) begin
			rd_char_q <= char_mem[cmd.raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shadow_we) begin
			shadow_mem[cmd.waddr[AW-1:0]] <= cmd.shadow_wdata;
		end
		if (cmd.re) begin
			rd_shadow_q <= shadow_mem[cmd.raddr[AW-1:0]];
		end
	end

	assign rd_char   = rd_char_q;
	assign rd_shadow = rd_shadow_q;

endmodule

[hw/rtl/odcre_result_queue.sv]
// ----------------------------------------------------------------------------
// odcre_result_queue
// Holds the register writes of one refresh pass and drains them through an
// output register once the pass is complete.
// ----------------------------------------------------------------------------
module odcre_result_queue import odcre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_push_t    push,
	input  q_start_t   start,
	output logic       busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] reg_addr,
	output logic [7:0] reg_value,
	output logic       write_valid,
	output logic       last,
	output logic       more_pending
);

	q_entry_t         q_mem [QDEPTH];
	q_entry_t         rdata_q;
	q_state_t         state_q;
	q_state_t         state_d;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] idx_q;
	logic             more_q;
	logic             re;
	logic             load;
	logic             load_ok;
	logic             is_empty;
	logic             is_last;
	logic             out_valid_q;
	logic [7:0]       reg_addr_q;
	logic [7:0]       reg_value_q;
	logic             write_valid_q;
	logic             last_q;
	logic             more_pending_q;

	assign load_ok  = !out_valid_q || !out_stall;
	assign is_empty = (total_q == '0);
	assign is_last  = is_empty || ((idx_q + CNT_W'(1)) == total_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			Q_IDLE: begin
				if (start.start) begin
					state_d = Q_READ;
				end
			end
			Q_READ: state_d = Q_LOAD;
			Q_LOAD: begin
				if (load_ok) begin
					state_d = is_last ? Q_IDLE : Q_READ;
				end
			end
			default: state_d = Q_IDLE;
		endcase
	end

	always_comb begin
		re   = (state_q == Q_READ);
		load = (state_q == Q_LOAD) && load_ok;
		busy = (state_q != Q_IDLE);
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			q_mem[push.idx] <= '{sel: push.sel, value: push.value};
		end
		if (re) begin
			rdata_q <= q_mem[idx_q[QAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_IDLE;
			idx_q       <= '0;
			total_q     <= '0;
			more_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == Q_IDLE) && start.start) begin
				idx_q   <= '0;
				total_q <= start.total;
				more_q  <= start.more;
			end else if (load) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			write_valid_q  <= !is_empty;
			reg_addr_q     <= is_empty ? 8'h00 : sel_addr(rdata_q.sel);
			reg_value_q    <= is_empty ? 8'h00 : rdata_q.value;
			last_q         <= is_last;
			more_pending_q <= more_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign reg_addr     = reg_addr_q;
	assign reg_value    = reg_value_q;
	assign write_valid  = write_valid_q;
	assign last         = last_q;
	assign more_pending = more_pending_q;

endmodule

[hw/rtl/odcre_ctrl.sv]
// ----------------------------------------------------------------------------
// odcre_ctrl
// Request sequencer: character writes, clearing sweeps and the refresh scan
// that compares the character store with the shadow and encodes writes.
// ----------------------------------------------------------------------------
module odcre_ctrl import odcre_pkg::*; #(
	parameter int COLS         = COLS_DEF,
	parameter int ROWS         = ROWS_DEF,
	parameter int BUFFER_CHARS = BUFFER_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ACT_W-1:0] active_chars,
	input  logic             invert_pixels,
	input  logic [BUD_W-1:0] write_budget,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [5:0]       col,
	input  logic [4:0]       row,
	input  logic [7:0]       char_code,
	output mem_cmd_t         mem_cmd,
	input  logic [7:0]       rd_char,
	input  logic [7:0]       rd_shadow,
	output q_push_t          q_push,
	output q_start_t         q_start,
	input  logic             q_busy
);

	ctrl_state_t      state_q;
	ctrl_state_t      state_d;
	logic [ACT_W-1:0] pos_q;
	logic [ACT_W-1:0] n_q;
	logic [ACT_W:0]   limit_q;
	logic [BUD_W-1:0] budget_q;
	logic [CNT_W-1:0] cnt_q;
	logic             need_addr_q;
	logic             auto_inc_q;
	wr_sel_t          step_q;
	logic             ff_q;
	logic [7:0]       cur_c_q;
	logic [7:0]       cur_s_q;
	logic [7:0]       dval_q;
	logic [XW-1:0]    clr_q;
	logic [XW-1:0]    clr_end_q;
	logic             clr_char_q;
	logic             clr_shadow_q;

	logic             accept;
	logic [XW-1:0]    wr_idx;
	logic             wr_ok;
	logic [ACT_W-1:0] n_cfg;
	logic [BUD_W-1:0] bud_cfg;
	logic [ACT_W-1:0] start_pos;
	logic [ACT_W:0]   pos1;
	logic             at_end;
	logic             loop_ok;
	logic             changed;
	logic             nchg;
	logic             eval_emit;
	logic             advance;
	logic [7:0]       dval;
	logic [7:0]       emit_value;
	logic [7:0]       mode_plain;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign wr_idx    = XW'(row) * XW'(COLS) + XW'(col);
	assign wr_ok     = (XW'(col) < XW'(COLS)) && (XW'(row) < XW'(ROWS))
	                   && (wr_idx < XW'(BUFFER_CHARS));
	assign n_cfg     = (XW'(active_chars) < XW'(BUFFER_CHARS)) ? active_chars
	                   : ACT_W'(BUFFER_CHARS);
	assign bud_cfg   = (write_budget < BUDGET_CAP) ? write_budget : BUDGET_CAP;
	assign start_pos = (pos_q >= n_cfg) ? '0 : pos_q;
	assign pos1      = {1'b0, pos_q} + (ACT_W+1)'(1);
	assign at_end    = (pos1 >= {1'b0, n_q});
	assign mode_plain = {4'b0, invert_pixels, 3'b0};

	always_comb begin
		loop_ok   = (cnt_q < {1'b0, budget_q}) && ({1'b0, pos_q} < limit_q);
		changed   = (cur_c_q != cur_s_q);
		nchg      = (pos1 < {1'b0, n_q}) && (rd_char != rd_shadow);
		eval_emit = changed || (!need_addr_q && auto_inc_q);
		dval      = (cur_c_q == RUN_END) ? SPACE : cur_c_q;
		advance   = ((state_q == ST_EVAL) && loop_ok && !eval_emit)
		            || ((state_q == ST_EMIT) && (step_q == WR_DATA));
	end

	always_comb begin
		case (step_q)
			WR_MODE: emit_value = {4'b0, invert_pixels, 2'b0, auto_inc_q};
			WR_HIGH: emit_value = {7'b0, pos_q[ACT_W-1]};
			WR_LOW:  emit_value = pos_q[7:0];
			WR_DATA: emit_value = ff_q ? RUN_END : dval_q;
			default: emit_value = 8'h00;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == clr_end_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_WRITE:   state_d = ST_IDLE;
						REQ_CLEAR:   state_d = ST_CLR;
						REQ_REDRAW:  state_d = (n_cfg != '0) ? ST_CLR : ST_IDLE;
						REQ_REFRESH: state_d = ST_PRIME;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_PRIME: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!loop_ok) begin
					state_d = ST_TAIL_FF;
				end else if (eval_emit) begin
					state_d = ST_EMIT;
				end else begin
					state_d = at_end ? ST_TAIL_FF : ST_EVAL;
				end
			end
			ST_EMIT: begin
				if (step_q == WR_DATA) begin
					state_d = at_end ? ST_TAIL_FF : ST_EVAL;
				end
			end
			ST_TAIL_FF:   state_d = ST_TAIL_MODE;
			ST_TAIL_MODE: state_d = ST_FLUSH;
			ST_FLUSH:     state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (!q_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		mem_cmd  = '0;
		q_push   = '0;
		q_start  = '0;
		q_push.idx   = cnt_q[QAW-1:0];
		q_start.total = cnt_q;
		q_start.more  = (pos_q != '0);
		case (state_q)
			ST_CLR: begin
				mem_cmd.char_we      = clr_char_q;
				mem_cmd.shadow_we    = clr_shadow_q;
				mem_cmd.waddr        = clr_q;
				mem_cmd.char_wdata   = SPACE;
				mem_cmd.shadow_wdata = 8'h00;
			end
			ST_IDLE: begin
				if (accept && (req_type == REQ_WRITE) && wr_ok) begin
					mem_cmd.char_we    = 1'b1;
					mem_cmd.waddr      = wr_idx;
					mem_cmd.char_wdata = char_code;
				end
				if (accept && (req_type == REQ_REFRESH)) begin
					mem_cmd.re    = 1'b1;
					mem_cmd.raddr = XW'(start_pos);
				end
			end
			ST_PRIME: begin
				mem_cmd.re    = 1'b1;
				mem_cmd.raddr = XW'(pos_q) + XW'(1);
			end
			ST_EVAL: begin
				if (loop_ok && changed) begin
					mem_cmd.char_we      = 1'b1;
					mem_cmd.shadow_we    = 1'b1;
					mem_cmd.waddr        = XW'(pos_q);
					mem_cmd.char_wdata   = dval;
					mem_cmd.shadow_wdata = dval;
				end
			end
			ST_EMIT: begin
				q_push.push  = 1'b1;
				q_push.sel   = step_q;
				q_push.value = emit_value;
			end
			ST_TAIL_FF: begin
				q_push.push  = auto_inc_q && !need_addr_q;
				q_push.sel   = WR_DATA;
				q_push.value = RUN_END;
			end
			ST_TAIL_MODE: begin
				q_push.push  = auto_inc_q;
				q_push.sel   = WR_MODE;
				q_push.value = mode_plain;
			end
			ST_FLUSH: q_start.start = 1'b1;
			ST_DRAIN: q_start.start = 1'b0;
			default:  q_start.start = 1'b0;
		endcase
		// prefetch the lookahead entry for the position after the next one
		if (advance && !at_end) begin
			mem_cmd.re    = 1'b1;
			mem_cmd.raddr = XW'(pos_q) + XW'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			pos_q        <= '0;
			cnt_q        <= '0;
			need_addr_q  <= 1'b1;
			auto_inc_q   <= 1'b0;
			step_q       <= WR_MODE;
			ff_q         <= 1'b0;
			clr_q        <= '0;
			clr_end_q    <= XW'(BUFFER_CHARS - 1);
			clr_char_q   <= 1'b1;
			clr_shadow_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + XW'(1);
			end
			if (accept) begin
				case (req_type)
					REQ_CLEAR: begin
						clr_q        <= '0;
						clr_end_q    <= XW'(BUFFER_CHARS - 1);
						clr_char_q   <= 1'b1;
						clr_shadow_q <= 1'b0;
					end
					REQ_REDRAW: begin
						clr_q        <= '0;
						clr_end_q    <= XW'(n_cfg) - XW'(1);
						clr_char_q   <= 1'b0;
						clr_shadow_q <= 1'b1;
					end
					REQ_REFRESH: begin
						pos_q       <= start_pos;
						cnt_q       <= '0;
						need_addr_q <= 1'b1;
						auto_inc_q  <= 1'b0;
					end
					default: begin
						clr_q <= clr_q;
					end
				endcase
			end
			if ((state_q == ST_EVAL) && loop_ok) begin
				if (changed) begin
					ff_q <= 1'b0;
					if (need_addr_q || !auto_inc_q) begin
						auto_inc_q  <= nchg;
						need_addr_q <= 1'b0;
						step_q      <= WR_MODE;
					end else begin
						step_q <= WR_DATA;
					end
				end else if (!need_addr_q) begin
					need_addr_q <= 1'b1;
					step_q      <= WR_DATA;
					ff_q        <= 1'b1;
				end
			end
			if (state_q == ST_EMIT) begin
				step_q <= wr_sel_t'(step_q + 2'd1);
			end
			if (q_push.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (advance) begin
				pos_q <= at_end ? '0 : pos1[ACT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_REFRESH)) begin
			n_q      <= n_cfg;
			budget_q <= bud_cfg;
			limit_q  <= {1'b0, start_pos} + {2'b0, n_cfg[ACT_W-1:1]};
		end
		if ((state_q == ST_PRIME) || (advance && !at_end)) begin
			cur_c_q <= rd_char;
			cur_s_q <= rd_shadow;
		end
		if ((state_q == ST_EVAL) && loop_ok && changed) begin
			dval_q <= dval;
		end
	end

endmodule

[hw/rtl/osd_dirty_char_refresh_encoder_core.sv]
// ----------------------------------------------------------------------------
// osd_dirty_char_refresh_encoder_core
// Character write: stored on acceptance, ignored off the screen. Clear screen
// sweeps the character store, force redraw the active part of the shadow;
// both are sweeps of the store write port. Refresh: a prime step, a step per
// scanned character and per register write of the scan, then TAIL_FF,
// TAIL_MODE and FLUSH (closing writes included); requests wait for the queue to
// drain. After reset a clearing pass over BUFFER_CHARS (480) runs first.
// ----------------------------------------------------------------------------
module osd_dirty_char_refresh_encoder_core import odcre_pkg::*; #(
	parameter int COLS         = COLS_DEF,
	parameter int ROWS         = ROWS_DEF,
	parameter int BUFFER_CHARS = BUFFER_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [5:0]        col,
	input  logic [4:0]        row,
	input  logic [7:0]        char_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        reg_addr,
	output logic [7:0]        reg_value,
	output logic              write_valid,
	output logic              last,
	output logic              more_pending,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [ACT_W-1:0] active_chars_q;
	logic             invert_pixels_q;
	logic [BUD_W-1:0] write_budget_q;
	logic             cfg_wr;
	mem_cmd_t         mem_cmd;
	logic [7:0]       rd_char;
	logic [7:0]       rd_shadow;
	q_push_t          q_push;
	q_start_t         q_start;
	logic             q_busy;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_chars_q  <= ACTIVE_CHARS_RST;
			invert_pixels_q <= 1'b0;
			write_budget_q  <= WRITE_BUDGET_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ACTIVE_CHARS:  active_chars_q  <= pwdata[ACT_W-1:0];
				REG_INVERT_PIXELS: invert_pixels_q <= pwdata[0];
				REG_WRITE_BUDGET:  write_budget_q  <= pwdata[BUD_W-1:0];
				default:           active_chars_q  <= active_chars_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ACTIVE_CHARS:  prdata = {{(32-ACT_W){1'b0}}, active_chars_q};
			REG_INVERT_PIXELS: prdata = {31'b0, invert_pixels_q};
			REG_WRITE_BUDGET:  prdata = {{(32-BUD_W){1'b0}}, write_budget_q};
			default:           prdata = 32'h0;
		endcase
	end

	odcre_ctrl #(
		.COLS         (COLS),
		.ROWS         (ROWS),
		.BUFFER_CHARS (BUFFER_CHARS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.active_chars  (active_chars_q),
		.invert_pixels (invert_pixels_q),
		.write_budget  (write_budget_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.col           (col),
		.row           (row),
		.char_code     (char_code),
		.mem_cmd       (mem_cmd),
		.rd_char       (rd_char),
		.rd_shadow     (rd_shadow),
		.q_push        (q_push),
		.q_start       (q_start),
		.q_busy        (q_busy)
	);

	odcre_screen_mem #(
		.BUFFER_CHARS (BUFFER_CHARS)
	) u_screen_mem (
		.clk       (clk),
		.cmd       (mem_cmd),
		.rd_char   (rd_char),
		.rd_shadow (rd_shadow)
	);

	odcre_result_queue u_result_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (q_push),
		.start        (q_start),
		.busy         (q_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reg_addr     (reg_addr),
		.reg_value    (reg_value),
		.write_valid  (write_valid),
		.last         (last),
		.more_pending (more_pending)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the OSD dirty-character refresh encoder. A short
// directed table (small screens, budget and invert extremes, 0xFF characters,
// ignored positions, empty passes, clear and redraw) is followed by random
// requests over six register settings. Every display register write is
// checked against a bench-side screen/shadow model, under sender and
// receiver idling and one long output hold.
// ----------------------------------------------------------------------------
module tb import odcre_pkg::*; ();

	localparam int COLS          = COLS_DEF;
	localparam int ROWS          = ROWS_DEF;
	localparam int SCREEN_CHARS  = BUFFER_CHARS_DEF;
	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 2000;
	localparam int HOLD_CYCLES   = 800;
	localparam int RUN_LIMIT_NS  = 40_000_000;
	localparam int GROUP_ITEMS   = 66;
	localparam int NUM_SETTINGS  = 6;
	localparam int PRESSURE_SET  = 4;
	localparam int NUM_DIRECTED  = 26;

	localparam logic [7:0] MODE_AUTO_INC = 8'h01;
	localparam logic [7:0] MODE_INVERT   = 8'h08;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] value;
		logic       wv;
		logic       is_last;
		logic       more;
	} osd_write_t;

	typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_EMPTY} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [1:0] req;
		logic [5:0] col;
		logic [4:0] row;
		logic [7:0] code;
		logic [1:0] reg_sel;
		logic [8:0] reg_val;
		logic       empty_more;
	} bench_step_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type     = REQ_WRITE;
	logic [5:0]        col          = '0;
	logic [4:0]        row          = '0;
	logic [7:0]        char_code    = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [7:0]        reg_addr;
	logic [7:0]        reg_value;
	logic              write_valid;
	logic              last;
	logic              more_pending;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [CFG_AW-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;

	// screen model
	logic [7:0]       want_chars   [SCREEN_CHARS];
	logic [7:0]       shadow_chars [SCREEN_CHARS];
	int unsigned      scan_at;
	logic [ACT_W-1:0] cfg_active;
	logic             cfg_invert;
	logic [BUD_W-1:0] cfg_budget;

	osd_write_t pass_writes[$];
	osd_write_t pending_writes[$];

	int  send_idle      = 7;
	int  recv_idle      = 85;
	bit  pressure_armed = 1'b0;
	bit  hold_off       = 1'b0;
	int  error_count    = 0;
	int  requests_sent  = 0;
	int  refresh_count  = 0;
	int  writes_checked = 0;

	logic [8:0] set_active [NUM_SETTINGS] = '{9'd480, 9'd390, 9'd2, 9'd511, 9'd480, 9'd0};
	logic       set_invert [NUM_SETTINGS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	logic [5:0] set_budget [NUM_SETTINGS] = '{6'd61, 6'd20, 6'd4, 6'd63, 6'd59, 6'd0};

	bench_step_t directed_steps [NUM_DIRECTED] = '{
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd2,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_EMPTY, REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b1},
		'{STEP_EMPTY, REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_INVERT_PIXELS, 9'd1,   1'b0},
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_WRITE_BUDGET,  9'd4,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd0,  5'd0,  8'hFF, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd1,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd63, 5'd31, 8'h55, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd30, 5'd0,  8'hAA, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd0,  5'd16, 8'hAA, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_EMPTY, REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b1},
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd511, 1'b0},
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_WRITE_BUDGET,  9'd63,  1'b0},
		'{STEP_CFG,   REQ_WRITE,   6'd0,  5'd0,  8'h00, REG_INVERT_PIXELS, 9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd29, 5'd15, 8'hAB, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd28, 5'd15, 8'hFF, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_CLEAR,   6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_WRITE,   6'd29, 5'd15, 8'h01, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REDRAW,  6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0},
		'{STEP_REQ,   REQ_REFRESH, 6'd0,  5'd0,  8'h00, REG_ACTIVE_CHARS,  9'd0,   1'b0}
	};

	osd_dirty_char_refresh_encoder_core uut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(negedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < recv_idle);
	end

	initial begin : output_hold
		wait (pressure_armed);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	function automatic void add_write(logic [7:0] a, logic [7:0] v);
		pass_writes.push_back('{a, v, 1'b1, 1'b0, 1'b0});
	endfunction

	function automatic void encode_refresh();
		int unsigned n, budget, pos, lim;
		logic [7:0]  mode;
		bit          need_addr, auto_inc, next_dirty;
		n      = (cfg_active < SCREEN_CHARS) ? cfg_active : SCREEN_CHARS;
		budget = (cfg_budget < BUDGET_CAP) ? cfg_budget : BUDGET_CAP;
		mode   = cfg_invert ? MODE_INVERT : 8'h00;
		pos    = (scan_at >= n) ? 0 : scan_at;
		lim    = pos + n / 2;
		need_addr = 1'b1;
		auto_inc  = 1'b0;
		while (pass_writes.size() < budget && pos < lim) begin
			if (want_chars[pos] != shadow_chars[pos]) begin
				if (want_chars[pos] == RUN_END)
					want_chars[pos] = SPACE;
				if (need_addr || !auto_inc) begin
					// one past the active end never starts a run
					next_dirty = (pos + 1 < n) && (want_chars[pos+1] != shadow_chars[pos+1]);
					auto_inc   = next_dirty;
					add_write(ADDR_MODE, next_dirty ? (mode | MODE_AUTO_INC) : mode);
					add_write(ADDR_HIGH, 8'(pos >> 8));
					add_write(ADDR_LOW, 8'(pos));
					need_addr = 1'b0;
				end
				add_write(ADDR_DATA, want_chars[pos]);
				shadow_chars[pos] = want_chars[pos];
			end else if (!need_addr) begin
				need_addr = 1'b1;
				if (auto_inc)
					add_write(ADDR_DATA, RUN_END);
			end
			pos++;
			if (pos >= n) begin
				pos = 0;
				break;
			end
		end
		if (auto_inc) begin
			if (!need_addr)
				add_write(ADDR_DATA, RUN_END);
			add_write(ADDR_MODE, mode);
		end
		scan_at = pos;
		if (pass_writes.size() == 0)
			pass_writes.push_back('0);
		foreach (pass_writes[k])
			pass_writes[k].more = (pos != 0);
		pass_writes[pass_writes.size()-1].is_last = 1'b1;
	endfunction

	function automatic void apply_request(logic [1:0] req, logic [5:0] c, logic [4:0] r,
			logic [7:0] code);
		int unsigned idx, n;
		pass_writes.delete();
		case (req)
			REQ_WRITE: begin
				if (c < COLS && r < ROWS) begin
					idx = r * COLS + c;
					if (idx < SCREEN_CHARS)
						want_chars[idx] = code;
				end
			end
			REQ_CLEAR: begin
				foreach (want_chars[i])
					want_chars[i] = SPACE;
			end
			REQ_REDRAW: begin
				n = (cfg_active < SCREEN_CHARS) ? cfg_active : SCREEN_CHARS;
				for (int i = 0; i < n; i++)
					shadow_chars[i] = 8'h00;
			end
			default: encode_refresh();
		endcase
	endfunction

	// entered and left at a falling edge; in_valid stays high on return, so
	// the caller drives it again in the same step
	task automatic send_request(input logic [1:0] req, input logic [5:0] c,
			input logic [4:0] r, input logic [7:0] code,
			input bit empty_typed = 1'b0, input bit typed_more = 1'b0);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		col       <= c;
		row       <= r;
		char_code <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(req, c, r, code);
		if (empty_typed)
			pending_writes.push_back('{8'h00, 8'h00, 1'b0, 1'b1, typed_more});
		else
			foreach (pass_writes[k])
				pending_writes.push_back(pass_writes[k]);
		requests_sent++;
		if (req == REQ_REFRESH)
			refresh_count++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'({sel, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (sel)
			REG_ACTIVE_CHARS:  cfg_active = val[ACT_W-1:0];
			REG_INVERT_PIXELS: cfg_invert = val[0];
			REG_WRITE_BUDGET:  cfg_budget = val[BUD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		int         pick, len;
		logic [5:0] c;
		logic [4:0] r;
		logic [7:0] code;
		pick = $urandom_range(99);
		if (pick < 45) begin
			c   = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(COLS-1));
			r   = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(ROWS-1));
			len = ($urandom_range(3) == 0) ? $urandom_range(6, 2) : 1;
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(7))
					0:       code = RUN_END;
					1:       code = SPACE;
					2:       code = 8'h00;
					default: code = 8'($urandom);
				endcase
				send_request(REQ_WRITE, c + 6'(k), r, code);
			end
		end else if (pick < 50) begin
			send_request(REQ_CLEAR, 6'($urandom), 5'($urandom), 8'($urandom));
		end else if (pick < 58) begin
			send_request(REQ_REDRAW, 6'($urandom), 5'($urandom), 8'($urandom));
		end else begin
			send_request(REQ_REFRESH, 6'($urandom), 5'($urandom), 8'($urandom));
		end
	endtask

	always @(posedge clk) begin : result_check
		osd_write_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{reg_addr, reg_value, write_valid, last, more_pending};
			if (pending_writes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected write, expected none, actual %h %h %b %b %b",
					$time, got.addr, got.value, got.wv, got.is_last, got.more);
			end else begin
				want = pending_writes.pop_front();
				writes_checked++;
				if (got !== want) begin
					error_count++;
					$display("%0t: expected %h %h %b %b %b, actual %h %h %b %b %b",
						$time, want.addr, want.value, want.wv, want.is_last, want.more,
						got.addr, got.value, got.wv, got.is_last, got.more);
				end
			end
		end
	end

	initial begin : stimulus
		int target;
		foreach (want_chars[i]) begin
			want_chars[i]   = SPACE;
			shadow_chars[i] = 8'h00;
		end
		scan_at    = 0;
		cfg_active = ACTIVE_CHARS_RST;
		cfg_invert = 1'b0;
		cfg_budget = WRITE_BUDGET_RST;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[i]) begin
			case (directed_steps[i].kind)
				STEP_CFG: begin
					in_valid <= 1'b0;
					wait_idle();
					write_reg(directed_steps[i].reg_sel, 32'(directed_steps[i].reg_val));
				end
				STEP_EMPTY: begin
					send_request(REQ_REFRESH, 6'd0, 5'd0, 8'h00, 1'b1,
						directed_steps[i].empty_more);
				end
				default: begin
					send_request(directed_steps[i].req, directed_steps[i].col,
						directed_steps[i].row, directed_steps[i].code);
				end
			endcase
		end

		for (int g = 0; g < NUM_SETTINGS; g++) begin
			case (g / 2)
				0:       begin send_idle = 7;  recv_idle = 85; end
				1:       begin send_idle = 85; recv_idle = 7;  end
				default: begin send_idle = 0;  recv_idle = 0;  end
			endcase
			if (g == NUM_SETTINGS - 1) begin
				set_active[g] = 9'($urandom_range(480, 2));
				set_invert[g] = 1'($urandom);
				set_budget[g] = 6'($urandom_range(63, 4));
			end
			in_valid <= 1'b0;
			wait_idle();
			write_reg(REG_ACTIVE_CHARS, 32'(set_active[g]));
			write_reg(REG_INVERT_PIXELS, 32'(set_invert[g]));
			write_reg(REG_WRITE_BUDGET, 32'(set_budget[g]));
			target = requests_sent + GROUP_ITEMS;
			if (g == PRESSURE_SET) begin
				// full redraw, then hold the output so that refresh requests stall behind it
				send_request(REQ_REDRAW, 6'd0, 5'd0, 8'h00);
				pressure_armed = 1'b1;
				repeat (6) send_request(REQ_REFRESH, 6'd0, 5'd0, 8'h00);
			end
			while (requests_sent < target)
				send_random();
		end

		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests including %0d refresh passes; %0d register writes checked",
			requests_sent, refresh_count, writes_checked);
		$display("across %0d register settings, with idling on both sides and one long hold.",
			NUM_SETTINGS);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
